FILE: rtl/rpc_pkg.sv
package rpc_pkg;

    localparam int TARGET_W = 13;
    localparam int PART_W   = 3;
    localparam int COUNT_W  = 63;

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_LOOKUP,
        ST_FETCH
    } rpc_state_t;

endpackage

FILE: rtl/rpc_table.sv
module rpc_table
    import rpc_pkg::*;
#(
    parameter int ADDR_W = 15
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COUNT_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [COUNT_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [COUNT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/rpc_seq.sv
module rpc_seq
    import rpc_pkg::*;
#(
    parameter int MAX_VALUE = 8192,
    parameter int MAX_PART  = 4,
    parameter int ROW_W     = 13,
    parameter int COL_W     = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [TARGET_W-1:0]      target_value,
    input  logic [PART_W-1:0]        largest_part,
    output logic                     busy,
    output logic                     res_valid,
    output logic [COUNT_W-1:0]       res_value,
    output logic                     wr_en,
    output logic [ROW_W+COL_W-1:0]   wr_addr,
    output logic [COUNT_W-1:0]       wr_data,
    output logic                     rd_en,
    output logic [ROW_W+COL_W-1:0]   rd_addr,
    input  logic [COUNT_W-1:0]       rd_data
);

    localparam int STEP_W = $clog2(MAX_PART + 1);

    rpc_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ROW_W:0]      rows_reg, rows_next;
    logic [COUNT_W-1:0]  acc_reg, acc_next;
    logic                used_reg, used_next;
    logic [ROW_W:0]      row_tgt_reg, row_tgt_next;
    logic [COL_W-1:0]    col_reg, col_next;

    logic                accept;
    logic                in_range;
    logic [16:0]         target_ext;
    logic [ROW_W:0]      target_row;
    logic [4:0]          part_clamped;
    logic [ROW_W-1:0]    cur_row;
    logic [ROW_W-1:0]    src_row;
    logic [ROW_W:0]      step_ext;
    logic                last_step;
    logic                first_step;
    logic [COUNT_W:0]    sum;
    logic [COUNT_W-1:0]  sum_sat;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign target_ext = {4'd0, target_value};
    assign target_row = target_ext[ROW_W:0];
    assign in_range   = ({19'd0, target_value} < 32'(MAX_VALUE));

    assign part_clamped = ({2'd0, largest_part} > 5'(MAX_PART)) ? 5'(MAX_PART)
                                                                : {2'd0, largest_part};

    assign cur_row    = rows_reg[ROW_W-1:0];
    assign step_ext   = (ROW_W+1)'(step_reg);
    assign src_row    = cur_row - step_ext[ROW_W-1:0] - ROW_W'(1);
    assign last_step  = (step_reg == STEP_W'(MAX_PART));
    assign first_step = (step_reg == '0);

    // p(n,j) = p(n,j-1) + p(n-j,j), held at the top of the range
    assign sum     = {1'b0, acc_reg} + {1'b0, (used_reg ? rd_data : '0)};
    assign sum_sat = sum[COUNT_W] ? COUNT_SAT : sum[COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            rows_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rows_reg  <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        used_reg    <= used_next;
        row_tgt_reg <= row_tgt_next;
        col_reg     <= col_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range && (largest_part != '0))
                begin
                    state_next = (rows_reg <= target_row) ? ST_BUILD : ST_LOOKUP;
                end
            end
            ST_BUILD:
            begin
                if (last_step && (rows_reg >= row_tgt_reg))
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        step_next    = step_reg;
        rows_next    = rows_reg;
        acc_next     = acc_reg;
        used_next    = used_reg;
        row_tgt_next = row_tgt_reg;
        col_next     = col_reg;
        res_valid    = 1'b0;
        res_value    = '0;
        wr_en        = 1'b0;
        wr_addr      = {cur_row, COL_W'(step_reg - STEP_W'(1))};
        wr_data      = sum_sat;
        rd_en        = 1'b0;
        rd_addr      = {src_row, COL_W'(step_reg)};

        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    row_tgt_next = target_row;
                    col_next     = COL_W'(part_clamped - 5'd1);
                    if (!in_range || (largest_part == '0))
                    begin
                        res_valid = 1'b1;
                        res_value = (in_range && (target_value == '0)) ? COUNT_W'(1) : '0;
                    end
                end
            end
            ST_BUILD:
            begin
                if (!last_step)
                begin
                    rd_en     = (rows_reg > step_ext);
                    used_next = (rows_reg > step_ext);
                end
                if (first_step)
                begin
                    acc_next = (rows_reg == '0) ? COUNT_W'(1) : '0;
                end
                else
                begin
                    acc_next = sum_sat;
                    wr_en    = 1'b1;
                end
                if (last_step)
                begin
                    rows_next = rows_reg + (ROW_W+1)'(1);
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_LOOKUP:
            begin
                rd_en   = 1'b1;
                rd_addr = {row_tgt_reg[ROW_W-1:0], col_reg};
            end
            ST_FETCH:
            begin
                res_valid = 1'b1;
                res_value = rd_data;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

endmodule

FILE: rtl/restricted_partition_counter.sv
// timing: a target out of range or a largest part of zero is answered straight
// from idle; otherwise any missing rows up to the target are built first, one
// row after another through the single table read port, then the word is read
// queries: a new query is taken only once the sequencer is idle again
// reset: rst_n asynchronous active low clears the row count and the fsm;
// the table itself is not cleared, rows are only read once built

module restricted_partition_counter
    import rpc_pkg::*;
#(
    parameter int MAX_VALUE = 8192,
    parameter int MAX_PART  = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [TARGET_W-1:0] target_value,
    input  logic [PART_W-1:0]   largest_part,
    output logic                done,
    output logic [COUNT_W-1:0]  partition_count
);

    // table rows indexed by target, columns by part size less one
    localparam int ROW_W  = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
    localparam int COL_W  = (MAX_PART > 1) ? $clog2(MAX_PART) : 1;
    localparam int ADDR_W = ROW_W + COL_W;

    logic               res_valid;
    logic [COUNT_W-1:0] res_value;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COUNT_W-1:0] rd_data;

    logic               done_reg;
    logic [COUNT_W-1:0] count_reg;

    // sequencer: builds rows lazily then looks up the answer
    rpc_seq #(
        .MAX_VALUE (MAX_VALUE),
        .MAX_PART  (MAX_PART),
        .ROW_W     (ROW_W),
        .COL_W     (COL_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .target_value (target_value),
        .largest_part (largest_part),
        .busy         (busy),
        .res_valid    (res_valid),
        .res_value    (res_value),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    // count table, one write and one registered read per cycle; a row being
    // built only reads earlier rows, so no entry is read and written together
    rpc_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output word register, strobe held for one cycle only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            count_reg <= res_value;
        end
    end

    assign done            = done_reg;
    assign partition_count = count_reg;

endmodule

FILE: rtl/rpc_checker.sv
module rpc_checker
    import rpc_pkg::*;
#(
    parameter int MAX_VALUE = 8192
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [TARGET_W-1:0] target_value,
    input logic [PART_W-1:0]   largest_part,
    input logic                done,
    input logic [COUNT_W-1:0]  partition_count
);

    // no word is delivered while a query is still in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // the end of a lookup always delivers its word
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a word");

    // largest part zero answers at once: one for target zero, else zero
    a_part_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (largest_part == '0)) |=>
            (done && !busy &&
             (partition_count == (($past(target_value) == '0) ? COUNT_W'(1) : '0))))
        else $error("wrong answer for largest part zero");

    // an in-range query with a nonzero part goes to the table
    a_table_query: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (largest_part != '0) &&
         ({19'd0, target_value} < 32'(MAX_VALUE))) |=> (busy && !done))
        else $error("table query not started");

endmodule

bind restricted_partition_counter rpc_checker #(
    .MAX_VALUE (MAX_VALUE)
) u_rpc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .target_value    (target_value),
    .largest_part    (largest_part),
    .done            (done),
    .partition_count (partition_count)
);

FILE: verif/tb_restricted_partition_counter.sv
module tb_restricted_partition_counter;
    import rpc_pkg::*;

    localparam int MAX_VALUE      = 8192;
    localparam int MAX_PART       = 4;
    // longest quiet spell of a correct run is the full table build of
    // MAX_VALUE rows, so the limit allows several times its length
    localparam int WATCHDOG_LIMIT = 200000;
    // settle time after the last word, well past the lookup latency
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_GAP        = 12;
    localparam int N_DIRECTED     = 25;

    // scoreboard: own copy of the count table, grown lazily as queries arrive
    class partition_count_board;
        bit [COUNT_W-1:0]   count_tbl [MAX_VALUE][MAX_PART];
        int unsigned        rows_built;
        logic [COUNT_W-1:0] expected_counts [$];
        int unsigned        n_noted;
        int unsigned        n_checked;
        int unsigned        n_errors;

        function new();
            rows_built = 0;
            n_noted    = 0;
            n_checked  = 0;
            n_errors   = 0;
        endfunction

        function void note_query(logic [TARGET_W-1:0] target, logic [PART_W-1:0] part);
            int unsigned      n;
            int unsigned      k;
            int unsigned      j;
            bit [COUNT_W:0]   acc;
            bit [COUNT_W-1:0] add;
            bit [COUNT_W-1:0] want;
            n = target;
            k = part;
            if (n >= MAX_VALUE) begin
                want = '0;
            end
            else begin
                // p(n,j) = p(n,j-1) + p(n-j,j), p(n,0) = (n == 0), saturating
                while (rows_built <= n) begin
                    acc = (rows_built == 0) ? (COUNT_W+1)'(1) : '0;
                    for (j = 1; j <= MAX_PART; j++) begin
                        add = (rows_built >= j) ? count_tbl[rows_built - j][j - 1] : '0;
                        acc = acc + {1'b0, add};
                        if (acc > {1'b0, COUNT_SAT})
                            acc = {1'b0, COUNT_SAT};
                        count_tbl[rows_built][j - 1] = acc[COUNT_W-1:0];
                    end
                    rows_built++;
                end
                if (k > MAX_PART)
                    k = MAX_PART;
                if (k == 0)
                    want = (n == 0) ? COUNT_W'(1) : '0;
                else
                    want = count_tbl[n][k - 1];
            end
            expected_counts.insert(expected_counts.size(), want);
            n_noted++;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            n_errors++;
        endtask

        task check_count(logic [COUNT_W-1:0] got);
            logic [COUNT_W-1:0] want;
            n_checked++;
            if (expected_counts.size() == 0) begin
                report_mismatch($sformatf("unexpected word, partition_count %0d", got));
            end
            else begin
                want = expected_counts.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("word %0d: partition_count %0d, expected %0d",
                                              n_checked, got, want));
            end
        endtask
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic [TARGET_W-1:0] target_value = '0;
    logic [PART_W-1:0]   largest_part = '0;
    logic                busy;
    logic                done;
    logic [COUNT_W-1:0]  partition_count;

    partition_count_board count_board = new;
    int unsigned          quiet_cycles = 0;

    // directed words: zero targets, zero and over-range parts, a lazy build
    // that grows step by step, then the very top of the target range
    int dir_target [N_DIRECTED] = '{0, 0, 0, 1, 1, 2, 3, 4, 5, 5, 6, 7, 10, 10,
                                    40, 40, 100, 99, 1000, 4095, 8191, 8191,
                                    8191, 8191, 8190};
    int dir_part   [N_DIRECTED] = '{0, 1, 7, 0, 1, 2, 3, 4, 0, 3, 5, 6, 7, 4,
                                    2, 1, 4, 3, 4, 2, 4, 0, 7, 1, 3};

    always #5 clk = ~clk;

    restricted_partition_counter #(
        .MAX_VALUE (MAX_VALUE),
        .MAX_PART  (MAX_PART)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .target_value    (target_value),
        .largest_part    (largest_part),
        .done            (done),
        .partition_count (partition_count)
    );

    // monitor: sample pre-edge values; result first, since a word accepted
    // at this edge cannot have its answer at the same edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            count_board.check_count(partition_count);
        if (rst_n && start && !busy)
            count_board.note_query(target_value, largest_part);
        // watchdog on cycles with no traffic in either direction
        if (rst_n && ((start && !busy) || done))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // offer one query word, with a random run of idle cycles ahead of it;
    // start stays high into the next word when no gap is drawn
    task send_query(input logic [TARGET_W-1:0] target, input logic [PART_W-1:0] part,
                    input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        target_value <= target;
        largest_part <= part;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every outstanding answer is back; one edge first so
    // the monitor has logged the last accepted word
    task wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (count_board.expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly uniform over the whole range, plus a cluster of tiny targets
    // and the two ends of the field
    function automatic logic [TARGET_W-1:0] pick_target();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return TARGET_W'($urandom_range(0, 15));
        if (sel < 40)
        begin
            case (sel % 4)
                0: return '0;
                1: return TARGET_W'(1);
                2: return TARGET_W'(MAX_VALUE - 2);
                default: return TARGET_W'(MAX_VALUE - 1);
            endcase
        end
        return TARGET_W'($urandom_range(0, MAX_VALUE - 1));
    endfunction

    initial
    begin
        int phase;
        int idle_pct;
        int i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_query(TARGET_W'(dir_target[i]), PART_W'(dir_part[i]), 16);
        wait_drained();

        // sender idling heavy-ish, then heavier, then back to back
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 16 : (phase == 1) ? 55 : 0;
            for (i = 0; i < 475; i++)
                send_query(pick_target(), PART_W'($urandom_range(0, 7)), idle_pct);
            wait_drained();
        end

        $display("ran %0d query words (%0d directed, three random idling phases)",
                 count_board.n_noted, N_DIRECTED);
        $display("checked %0d answers over %0d table rows, %0d mismatches",
                 count_board.n_checked, count_board.rows_built, count_board.n_errors);
        if (count_board.n_errors == 0 && count_board.expected_counts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
